// ===== sv/rkhr_pkg.sv =====
// ============================================================================
// rkhr_pkg
// Shared types, widths, codes and scan tables of the reactive key hue ripple.
// ============================================================================
package rkhr_pkg;

    localparam int LED_COUNT   = 48;
    localparam int LED_IDX_W   = 6;
    localparam int HUE_W       = 8;
    localparam int KEY_MAP_W   = 60;
    localparam int TICK_W      = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [HUE_W-1:0] PRESS_OFFSET = 8'd128;
    localparam logic [HUE_W-1:0] MIN_PERIOD   = 8'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_DISABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HUE_PERIOD     = 1'b1;

    // Scan order: map bit of each lit key
    localparam logic [5:0] SCAN_BIT [LED_COUNT] = '{
         6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd7,  6'd8,  6'd9, 6'd10, 6'd11,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35,
        6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47,
        6'd48, 6'd49, 6'd50, 6'd51, 6'd56, 6'd57, 6'd58, 6'd59
    };

    // Scan order: LED number of each lit key
    localparam logic [LED_IDX_W-1:0] SCAN_LED [LED_COUNT] = '{
        6'd28, 6'd27, 6'd26, 6'd25, 6'd24,  6'd0,  6'd1,  6'd2,  6'd3,  6'd4,
        6'd33, 6'd32, 6'd31, 6'd30, 6'd29,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
        6'd43, 6'd42, 6'd41, 6'd40, 6'd39, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
        6'd47, 6'd46, 6'd45, 6'd44, 6'd20, 6'd21, 6'd22, 6'd23
    };

    // LED of the final key in scan order
    localparam logic [LED_IDX_W-1:0] LAST_LED_INDEX = 6'd23;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] tick;
        logic [HUE_W-1:0]  period;
        logic [HUE_W-1:0]  half;
    } rkhr_div_req_t;

    typedef struct packed {
        logic done;
        logic period_hit;
        logic half_hit;
    } rkhr_div_rsp_t;

    typedef struct packed {
        logic                 en;
        logic [LED_IDX_W-1:0] addr;
    } rkhr_rd_req_t;

    typedef struct packed {
        logic                 en;
        logic [LED_IDX_W-1:0] addr;
        logic [HUE_W-1:0]     data;
    } rkhr_wr_req_t;

endpackage

// ===== sv/rkhr_if.sv =====
// ============================================================================
// rkhr_if
// Valid/ready channels: key map requests in, LED hue requests out.
// ============================================================================
interface rkhr_key_if;
    logic                              valid;
    logic                              ready;
    logic [rkhr_pkg::KEY_MAP_W-1:0]    key_pressed_map;

    modport source (output valid, output key_pressed_map, input ready);
    modport sink   (input valid, input key_pressed_map, output ready);
endinterface

interface rkhr_led_if;
    logic                              valid;
    logic                              ready;
    logic [rkhr_pkg::LED_IDX_W-1:0]    led_index;
    logic [rkhr_pkg::HUE_W-1:0]        led_hue;
    logic                              last_led;

    modport source (output valid, output led_index, output led_hue, output last_led,
                    input ready);
    modport sink   (input valid, input led_index, input led_hue, input last_led,
                    output ready);
endinterface

// ===== sv/rkhr_rem.sv =====
// ============================================================================
// rkhr_rem
// Two-bit-per-cycle remainder unit: tick mod period and tick mod half period.
// ============================================================================
module rkhr_rem (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rkhr_pkg::rkhr_div_req_t req,
    output rkhr_pkg::rkhr_div_rsp_t rsp
);
    import rkhr_pkg::*;

    localparam int         DIV_STEPS = TICK_W / 2;
    localparam int         STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [TICK_W-1:0]   dividend_reg;
    logic [HUE_W-1:0]    period_reg;
    logic [HUE_W-1:0]    half_reg;
    logic [HUE_W-1:0]    rem_p_reg;
    logic [HUE_W-1:0]    rem_h_reg;
    logic [HUE_W-1:0]    rem_p_next;
    logic [HUE_W-1:0]    rem_h_next;

    // Shift one dividend bit into a remainder that stays below the divisor
    function automatic logic [HUE_W-1:0] rem_step(input logic [HUE_W-1:0] r,
                                                  input logic             b,
                                                  input logic [HUE_W-1:0] d);
        logic [HUE_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[HUE_W-1:0];
    endfunction

    always_comb
    begin
        rem_p_next = rem_step(rem_step(rem_p_reg, dividend_reg[TICK_W-1], period_reg),
                              dividend_reg[TICK_W-2], period_reg);
        rem_h_next = rem_step(rem_step(rem_h_reg, dividend_reg[TICK_W-1], half_reg),
                              dividend_reg[TICK_W-2], half_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start) begin
            dividend_reg <= req.tick;
            period_reg   <= req.period;
            half_reg     <= req.half;
            rem_p_reg    <= '0;
            rem_h_reg    <= '0;
        end else if (busy_reg) begin
            dividend_reg <= {dividend_reg[TICK_W-3:0], 2'b00};
            rem_p_reg    <= rem_p_next;
            rem_h_reg    <= rem_h_next;
        end
    end

    assign rsp.done       = done_reg;
    assign rsp.period_hit = (rem_p_reg == '0);
    assign rsp.half_hit   = (rem_h_reg == '0);

endmodule

// ===== sv/rkhr_offset_store.sv =====
// ============================================================================
// rkhr_offset_store
// Per-LED hue offset memory, registered read, with reset-cleared valid bits.
// ============================================================================
module rkhr_offset_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rkhr_pkg::rkhr_rd_req_t    rd,
    input  rkhr_pkg::rkhr_wr_req_t    wr,
    output logic [rkhr_pkg::HUE_W-1:0] rd_data
);
    import rkhr_pkg::*;

    logic [HUE_W-1:0] mem [LED_COUNT];
    logic [LED_COUNT-1:0] valid_reg;
    logic [HUE_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    // Entries never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/reactive_key_hue_ripple.sv =====
// ============================================================================
// reactive_key_hue_ripple
// Per-key reactive hue ripple: one key map request per frame tick, 48 LED
// hue requests out, offsets kept in a synchronous memory with registered read.
// ============================================================================
// Path from an accepted key map to the first LED request: the remainder
//   unit, the start of the walk, then the read-data stage and output register.
// Throughput: one LED per cycle in the walk unless the output stalls; the
//   next key map waits for idle. A disabled-effect request is dropped in idle.
// Reset: tick count and base hue clear, registers take their reset values;
//   offsets read as zero through per-entry valid bits, no clearing pass.
module reactive_key_hue_ripple (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rkhr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rkhr_pkg::CFG_DATA_W-1:0]     cfg_data,
    rkhr_key_if.sink                            keys,
    rkhr_led_if.source                          leds
);
    import rkhr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WALK
    } state_t;

    localparam logic [LED_IDX_W-1:0] LAST_K  = LED_IDX_W'(LED_COUNT - 1);
    localparam logic [LED_IDX_W-1:0] END_K   = LED_IDX_W'(LED_COUNT);

    // Configuration
    logic                 effect_disable_reg;
    logic [HUE_W-1:0]     hue_period_reg;

    // Control and tick state
    state_t               state_reg;
    logic [TICK_W-1:0]    tick_reg;
    logic [HUE_W-1:0]     base_hue_reg;
    logic                 decay_reg;
    logic [LED_IDX_W-1:0] k_reg;
    logic [KEY_MAP_W-1:0] keys_reg;

    // Read-data stage
    logic                 b_valid_reg;
    logic                 b_last_reg;
    logic                 b_key_reg;
    logic [LED_IDX_W-1:0] b_led_reg;

    // Output register
    logic                 out_valid_reg;
    logic [LED_IDX_W-1:0] out_led_reg;
    logic [HUE_W-1:0]     out_hue_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 adv;
    logic                 issue;
    logic [TICK_W-1:0]    tick_next;
    logic [HUE_W-1:0]     period_eff;
    logic [HUE_W-1:0]     off_rd;
    logic [HUE_W-1:0]     off_next;

    rkhr_div_req_t        div_req;
    rkhr_div_rsp_t        div_rsp;
    rkhr_rd_req_t         rd_req;
    rkhr_wr_req_t         wr_req;

    // Input side: take a key map only between ticks
    assign keys.ready = (state_reg == ST_IDLE);
    assign accept     = keys.valid && keys.ready;

    // The whole walk advances whenever the output register can take a value
    assign adv   = !out_valid_reg || leds.ready;
    assign issue = (state_reg == ST_WALK) && (k_reg != END_K) && adv;

    assign tick_next  = tick_reg + 1'b1;
    assign period_eff = (hue_period_reg < MIN_PERIOD) ? MIN_PERIOD : hue_period_reg;

    // Start remainder checks on the advanced tick count
    always_comb
    begin
        div_req.start  = accept && !effect_disable_reg;
        div_req.tick   = tick_next;
        div_req.period = period_eff;
        div_req.half   = {1'b0, period_eff[HUE_W-1:1]};
    end

    rkhr_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Read the next key's offset; decay it, override on press, write it back.
    // Each LED is visited once per tick, so read and write never collide.
    always_comb
    begin
        rd_req.en   = issue;
        rd_req.addr = SCAN_LED[k_reg];

        off_next = off_rd;
        if (off_rd != '0) begin
            off_next = off_rd - {{(HUE_W-1){1'b0}}, decay_reg};
        end
        if (b_key_reg) begin
            off_next = PRESS_OFFSET;
        end

        wr_req.en   = adv && b_valid_reg;
        wr_req.addr = b_led_reg;
        wr_req.data = off_next;
    end

    rkhr_offset_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd_req),
        .wr      (wr_req),
        .rd_data (off_rd)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            effect_disable_reg <= 1'b0;
            hue_period_reg     <= 8'd4;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_EFFECT_DISABLE: effect_disable_reg <= cfg_data[0];
                REG_HUE_PERIOD:     hue_period_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // State machine, tick state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            base_hue_reg  <= '0;
            decay_reg     <= 1'b0;
            k_reg         <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    // Drop ticks while the effect is off
                    if (accept && !effect_disable_reg) begin
                        tick_reg  <= tick_next;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_rsp.done) begin
                        if (div_rsp.period_hit) begin
                            base_hue_reg <= base_hue_reg + 1'b1;
                        end
                        decay_reg <= div_rsp.half_hit;
                        k_reg     <= '0;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (issue) begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (adv && b_valid_reg && b_last_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (adv) begin
                b_valid_reg   <= issue;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept) begin
            keys_reg <= keys.key_pressed_map;
        end
        if (issue) begin
            b_led_reg  <= SCAN_LED[k_reg];
            b_key_reg  <= keys_reg[SCAN_BIT[k_reg]];
            b_last_reg <= (k_reg == LAST_K);
        end
        if (adv && b_valid_reg) begin
            out_led_reg  <= b_led_reg;
            out_hue_reg  <= base_hue_reg - off_next;
            out_last_reg <= b_last_reg;
        end
    end

    assign leds.valid     = out_valid_reg;
    assign leds.led_index = out_led_reg;
    assign leds.led_hue   = out_hue_reg;
    assign leds.last_led  = out_last_reg;

endmodule

// ===== sv/rkhr_checker.sv =====
// ============================================================================
// rkhr_checker
// Port-level checks of the reactive key hue ripple, bound to the top level.
// ============================================================================
module rkhr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             key_valid,
    input logic                             key_ready,
    input logic                             led_valid,
    input logic                             led_ready,
    input logic [rkhr_pkg::LED_IDX_W-1:0]   led_index,
    input logic [rkhr_pkg::HUE_W-1:0]       led_hue,
    input logic                             last_led
);
    import rkhr_pkg::*;

    // A stalled request holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        led_valid && !led_ready |=> led_valid && $stable(led_index)
            && $stable(led_hue) && $stable(last_led))
        else $error("LED request changed while stalled");

    // The final key in scan order closes the tick, and only it
    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        led_valid |-> (last_led == (led_index == LAST_LED_INDEX)))
        else $error("last_led does not match the final LED");

    // No new key map is taken while a tick still has LEDs to deliver
    a_no_accept_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
        led_valid && !last_led |-> !key_ready)
        else $error("key map taken in the middle of a tick");

    // LED numbers stay on the board
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        led_valid |-> (led_index < 6'(LED_COUNT)))
        else $error("LED index out of range");

endmodule

bind reactive_key_hue_ripple rkhr_checker u_rkhr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_valid (keys.valid),
    .key_ready (keys.ready),
    .led_valid (leds.valid),
    .led_ready (leds.ready),
    .led_index (leds.led_index),
    .led_hue   (leds.led_hue),
    .last_led  (leds.last_led)
);

// ===== dv/tb_reactive_key_hue_ripple.sv =====
// ============================================================================
// tb_reactive_key_hue_ripple
// Self-checking bench for the per-key reactive hue ripple. Key map requests
// go in through a queue-fed driver. An in-bench model of the tick counter,
// base hue and per-LED offsets predicts the 48 LED hue requests of each
// tick, and a monitor checks them in order. Both channels stall at random.
// ============================================================================
module tb_reactive_key_hue_ripple;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W = rkhr_pkg::KEY_MAP_W;
    localparam int IDX_W = rkhr_pkg::LED_IDX_W;
    localparam int HUE_W = rkhr_pkg::HUE_W;
    localparam int CFG_W = rkhr_pkg::CFG_DATA_W;
    localparam int LEDS  = 48;

    localparam logic [HUE_W-1:0] PRESS_HUE_OFFSET = 8'd128;

    // Key map patterns for the directed part
    localparam logic [KEY_W-1:0] ALL_KEYS    = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] UNUSED_KEYS = 60'h0F0_060_060_060_060;
    localparam logic [KEY_W-1:0] ODD_KEYS    = {15{4'h5}};
    localparam logic [KEY_W-1:0] EVEN_KEYS   = {15{4'hA}};

    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 800000;

    typedef struct packed {
        logic [IDX_W-1:0] led;
        logic [HUE_W-1:0] hue;
        logic             last;
    } led_hue_t;

    typedef struct {
        logic [KEY_W-1:0] keys;
        int unsigned      gap;
    } key_map_req_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                cfg_we    = 1'b0;
    logic [rkhr_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]                    cfg_data  = '0;
    logic                                key_valid = 1'b0;
    logic [KEY_W-1:0]                    key_map   = '0;
    logic                                led_ready = 1'b0;

    rkhr_key_if key_ch ();
    rkhr_led_if led_ch ();

    assign key_ch.valid           = key_valid;
    assign key_ch.key_pressed_map = key_map;
    assign led_ch.ready           = led_ready;

    reactive_key_hue_ripple u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (key_ch),
        .leds      (led_ch)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Hue model state: mirrors the block's registers and offset store
    // ------------------------------------------------------------------------
    logic             cfg_disable = 1'b0;
    logic [CFG_W-1:0] cfg_period  = 8'd4;
    logic [31:0]      tick_cnt    = '0;
    logic [HUE_W-1:0] base_hue    = '0;
    logic [HUE_W-1:0] hue_off [LEDS];

    led_hue_t     hue_expect [$];
    key_map_req_t key_queue [$];

    int unsigned error_cnt      = 0;
    int unsigned tick_reqs      = 0;
    int unsigned disabled_ticks = 0;
    int unsigned checked_leds   = 0;
    int unsigned cycle_cnt      = 0;

    initial
    begin
        for (int i = 0; i < LEDS; i++)
        begin
            hue_off[i] = '0;
        end
    end

    // Advance the tick, decay and press offsets, and queue the 48 LED hues
    // in scan order. Scan slots: rows 0..3 carry ten keys each (columns 1..5
    // on the left half, 8..12 on the right); row 4 carries columns 1..4 and
    // 9..12.
    task automatic predict_tick(input logic [KEY_W-1:0] keys);
        int unsigned period;
        int unsigned half;
        logic [HUE_W-1:0] decay;
        logic [HUE_W-1:0] off;
        int row;
        int slot;
        int col;
        int led;
        led_hue_t res;
        if (cfg_disable)
        begin
            disabled_ticks++;
            return;
        end
        // Clamp a period below two so the half period never reaches zero
        period = (cfg_period < 2) ? 2 : int'(cfg_period);
        half   = period >> 1;
        tick_cnt = tick_cnt + 32'd1;
        if (tick_cnt % period == 0)
        begin
            base_hue = base_hue + 8'd1;
        end
        decay = (tick_cnt % half == 0) ? 8'd1 : 8'd0;
        for (int k = 0; k < LEDS; k++)
        begin
            if (k < 40)
            begin
                row  = k / 10;
                slot = k % 10;
                if (slot < 5)
                begin
                    col = slot + 1;
                    led = 28 + row * 5 - slot;
                end
                else
                begin
                    col = slot + 3;
                    led = row * 5 + slot - 5;
                end
            end
            else
            begin
                row  = 4;
                slot = k - 40;
                if (slot < 4)
                begin
                    col = slot + 1;
                    led = 47 - slot;
                end
                else
                begin
                    col = slot + 5;
                    led = 16 + slot;
                end
            end
            off = hue_off[led];
            if (off != 0)
            begin
                off = off - decay;
            end
            if (keys[row * 12 + col - 1])
            begin
                off = PRESS_HUE_OFFSET;
            end
            hue_off[led] = off;
            res.led  = IDX_W'(led);
            res.hue  = base_hue - off;
            res.last = (k == LEDS - 1);
            hue_expect.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued key map requests, honoring each one's gap
    // ------------------------------------------------------------------------
    int unsigned gap_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid <= 1'b0;
            key_map   <= '0;
            gap_count <= 0;
        end
        else if (!key_valid || key_ch.ready)
        begin
            // Slot is free: either nothing offered or the request just went in
            if (key_queue.size() > 0 && gap_count >= key_queue[0].gap)
            begin
                key_valid <= 1'b1;
                key_map   <= key_queue[0].keys;
                key_queue.delete(0);
                gap_count <= 0;
            end
            else
            begin
                key_valid <= 1'b0;
                if (key_queue.size() > 0)
                begin
                    gap_count <= gap_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // LED side back-pressure: random stall bursts plus one long hold-off
    // ------------------------------------------------------------------------
    logic rx_bursty = 1'b1;
    logic hold_go   = 1'b0;
    int   hold_left  = 0;
    int   stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_ready  <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
        end
        else if (hold_go)
        begin
            hold_left = HOLD_CYCLES;
            led_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            led_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            led_ready <= 1'b0;
        end
        else if (rx_bursty && $urandom_range(0, 7) == 0)
        begin
            // This cycle is the first of the burst
            stall_left = $urandom_range(0, 12);
            led_ready <= 1'b0;
        end
        else
        begin
            led_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check LED requests first, then predict for a new key map
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (led_ch.valid && led_ready)
            begin
                if (hue_expect.size() == 0)
                begin
                    $error("unexpected LED request: led_index %0d led_hue %0d last_led %0d",
                           led_ch.led_index, led_ch.led_hue, led_ch.last_led);
                    error_cnt++;
                end
                else
                begin
                    if (led_ch.led_index !== hue_expect[0].led)
                    begin
                        $error("led_index: expected %0d, actual %0d",
                               hue_expect[0].led, led_ch.led_index);
                        error_cnt++;
                    end
                    if (led_ch.led_hue !== hue_expect[0].hue)
                    begin
                        $error("led_hue: expected %0d, actual %0d",
                               hue_expect[0].hue, led_ch.led_hue);
                        error_cnt++;
                    end
                    if (led_ch.last_led !== hue_expect[0].last)
                    begin
                        $error("last_led: expected %0d, actual %0d",
                               hue_expect[0].last, led_ch.last_led);
                        error_cnt++;
                    end
                    hue_expect.delete(0);
                    checked_leds++;
                end
            end
            if (key_valid && key_ch.ready)
            begin
                tick_reqs++;
                predict_tick(key_map);
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Write one register; only called while the block is idle
    task automatic write_reg(input logic [rkhr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rkhr_pkg::REG_EFFECT_DISABLE)
        begin
            cfg_disable = data[0];
        end
        else
        begin
            cfg_period = data;
        end
        @(negedge clk);
    endtask

    // Hold until every request went in and every LED hue came back, then
    // let the block finish any disabled request still in flight
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (key_queue.size() != 0 || key_valid || hue_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_keys(input logic [KEY_W-1:0] keys, input bit bursty);
        key_map_req_t req;
        req.keys = keys;
        req.gap  = (bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        key_queue.push_back(req);
    endtask

    // Mostly quiet or sparse typing so offsets get to ripple down to zero,
    // with some dense random maps and full presses mixed in
    task automatic queue_random(input int count, input bit bursty);
        logic [KEY_W-1:0] keys;
        logic [63:0] wide;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            keys = '0;
            if (pick >= 4 && pick <= 6)
            begin
                for (int b = 0; b <= int'($urandom_range(0, 2)); b++)
                begin
                    keys[$urandom_range(0, KEY_W - 1)] = 1'b1;
                end
            end
            else if (pick == 7 || pick == 8)
            begin
                wide = {$urandom, $urandom};
                keys = wide[KEY_W-1:0];
            end
            else if (pick == 9)
            begin
                keys = ALL_KEYS;
            end
            queue_keys(keys, bursty);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: period 4, effect on. Drive the extremes of the map,
        // ignored bit positions only, and quiet ticks to watch the decay.
        queue_keys('0, 1'b1);
        queue_keys(ALL_KEYS, 1'b1);
        queue_keys('0, 1'b1);
        queue_keys('0, 1'b1);
        queue_keys('0, 1'b1);
        queue_keys(UNUSED_KEYS, 1'b1);
        queue_keys(ODD_KEYS, 1'b1);
        queue_keys(EVEN_KEYS, 1'b1);
        queue_keys(KEY_W'(1), 1'b1);
        queue_keys({1'b1, {(KEY_W-1){1'b0}}}, 1'b1);
        wait_drained();

        // Shortest period: decay steps on every tick, base hue on every second tick
        write_reg(rkhr_pkg::REG_HUE_PERIOD, 8'd2);
        queue_keys('0, 1'b1);
        queue_keys(ODD_KEYS, 1'b1);
        queue_keys('0, 1'b1);
        wait_drained();

        // Longest period
        write_reg(rkhr_pkg::REG_HUE_PERIOD, 8'd255);
        queue_keys(ALL_KEYS, 1'b1);
        queue_keys('0, 1'b1);
        queue_keys('0, 1'b1);
        wait_drained();

        // Periods below two behave as two
        write_reg(rkhr_pkg::REG_HUE_PERIOD, 8'd0);
        queue_keys(EVEN_KEYS, 1'b1);
        queue_keys('0, 1'b1);
        wait_drained();
        write_reg(rkhr_pkg::REG_HUE_PERIOD, 8'd1);
        queue_keys('0, 1'b1);
        queue_keys(UNUSED_KEYS, 1'b1);
        wait_drained();

        // Effect off: requests are swallowed and state stays put
        write_reg(rkhr_pkg::REG_EFFECT_DISABLE, 8'd1);
        queue_keys(ALL_KEYS, 1'b1);
        queue_keys('0, 1'b1);
        queue_keys(ODD_KEYS, 1'b1);
        wait_drained();
        write_reg(rkhr_pkg::REG_EFFECT_DISABLE, 8'd0);

        // Random: fast decay so offsets drain to zero and stick there
        write_reg(rkhr_pkg::REG_HUE_PERIOD, 8'd2);
        queue_random(40, 1'b1);
        wait_drained();

        // Random: small period; hold off the LED side for a long stretch
        // while key maps keep coming so the block backs up its input
        write_reg(rkhr_pkg::REG_HUE_PERIOD, CFG_W'($urandom_range(3, 16)));
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        queue_random(20, 1'b1);
        // Pause the sender until every LED hue is back, then resume
        wait_drained();
        queue_random(20, 1'b1);
        wait_drained();

        // Noise while disabled
        write_reg(rkhr_pkg::REG_EFFECT_DISABLE, 8'd1);
        queue_random(6, 1'b1);
        wait_drained();
        write_reg(rkhr_pkg::REG_EFFECT_DISABLE, 8'd0);

        // Random: any period
        write_reg(rkhr_pkg::REG_HUE_PERIOD, CFG_W'($urandom_range(2, 255)));
        queue_random(30, 1'b1);
        wait_drained();

        // Final stretch at full rate on both sides
        write_reg(rkhr_pkg::REG_HUE_PERIOD, CFG_W'($urandom_range(2, 8)));
        rx_bursty <= 1'b0;
        queue_random(30, 1'b0);
        wait_drained();

        $display("covered %0d key map requests (%0d while disabled), %0d LED hues checked",
                 tick_reqs, disabled_ticks, checked_leds);
        $display("periods 0, 1, 2, 4, 255 and random; long LED hold-off and drain pause");
        if (error_cnt == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== reactive_key_hue_ripple.f =====
sv/rkhr_pkg.sv
sv/rkhr_if.sv
sv/rkhr_rem.sv
sv/rkhr_offset_store.sv
sv/reactive_key_hue_ripple.sv
sv/rkhr_checker.sv
dv/tb_reactive_key_hue_ripple.sv
